### design/glpl_pkg.sv
`default_nettype none

package glpl_pkg;

    localparam int MAX_NODES       = 512;
    localparam int IDX_W           = $clog2(MAX_NODES);
    localparam int CNT_W           = $clog2(MAX_NODES + 1);
    localparam int H_W             = 24;
    localparam int L_W             = 24;
    localparam int GRADE_W         = 16;
    localparam int ITER_W          = 7;
    localparam int PROD_W          = GRADE_W + L_W;
    localparam int CAP_W           = H_W + 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int PASS_CAP        = 64;
    localparam int ONE_METRE       = 256;
    localparam int MIN_GRADE_NODES = 3;

    localparam logic [GRADE_W-1:0] GRADE_RESET = 16'd4588;
    localparam logic [ITER_W-1:0]  ITER_RESET  = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRADE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_RANGE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LOAD0,
        S_FWD_RD,
        S_FWD_MUL,
        S_FWD_CMP,
        S_BWD_RD,
        S_BWD_MUL,
        S_BWD_CMP,
        S_SEAM_RD,
        S_SEAM_MUL,
        S_SEAM_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             h_we;
        logic             l_we;
        logic [IDX_W-1:0] w_addr;
        logic [H_W-1:0]   h_wdata;
        logic [L_W-1:0]   l_wdata;
        logic             h_re;
        logic [IDX_W-1:0] h_raddr;
        logic             l_re;
        logic [IDX_W-1:0] l_raddr;
    } t_store_req;

endpackage

`default_nettype wire

### design/glpl_store.sv
`default_nettype none

module glpl_store (
    input  wire logic                     i_clk,
    input  wire glpl_pkg::t_store_req     i_req,
    output logic [glpl_pkg::H_W-1:0]      o_h_rdata,
    output logic [glpl_pkg::L_W-1:0]      o_l_rdata
);
    import glpl_pkg::*;

    logic [H_W-1:0] r_hmem [MAX_NODES];
    logic [L_W-1:0] r_lmem [MAX_NODES];
    logic [H_W-1:0] r_h_rdata;
    logic [L_W-1:0] r_l_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.h_we) begin
            r_hmem[i_req.w_addr] <= i_req.h_wdata;
        end
        if (i_req.h_re) begin
            r_h_rdata <= r_hmem[i_req.h_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.l_we) begin
            r_lmem[i_req.w_addr] <= i_req.l_wdata;
        end
        if (i_req.l_re) begin
            r_l_rdata <= r_lmem[i_req.l_raddr];
        end
    end

    assign o_h_rdata = r_h_rdata;
    assign o_l_rdata = r_l_rdata;

endmodule

`default_nettype wire

### design/grade_limited_profile_lowering.sv
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    command, natural_height, segment_length,
//                                          read_index, last
// result   out        o_valid / i_stall    kind, graded_height, node_count, iterations_used
// config   in         i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
// A load without last leaves input open; a read goes via store read, then result register.
// Grading walks the height store through one read-modify-write unit, read, multiply, compare
// per node; a pass goes forward, backward, then the seam, after a start and first-load setup.
// Synchronous active-low reset; stores hold no reset value; count, flags and config reset.
// While grading or while a read waits for the result register, o_stall stays high.
// A finished result waits in the output register while the next load is taken.
`default_nettype none

module grade_limited_profile_lowering (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_command,
    input  wire logic signed [glpl_pkg::H_W-1:0]  i_natural_height,
    input  wire logic [glpl_pkg::L_W-1:0]         i_segment_length,
    input  wire logic [glpl_pkg::IDX_W-1:0]       i_read_index,
    input  wire logic                             i_last,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [1:0]                            o_kind,
    output logic signed [glpl_pkg::H_W-1:0]       o_graded_height,
    output logic [glpl_pkg::CNT_W-1:0]            o_node_count,
    output logic [glpl_pkg::ITER_W-1:0]           o_iterations_used,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [glpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [glpl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import glpl_pkg::*;

    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_idx;
    logic signed [H_W-1:0]     r_prev;
    logic signed [H_W-1:0]     r_h0;
    logic signed [H_W-1:0]     r_hlast;
    logic signed [H_W-1:0]     r_hcur;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_moved;
    logic [ITER_W-1:0]         r_pass;
    logic [ITER_W-1:0]         r_used;
    logic [CNT_W-1:0]          r_count;
    logic                      r_set_done;
    logic [GRADE_W-1:0]        r_grade;
    logic [ITER_W-1:0]         r_max_iter;
    logic                      r_pend;
    t_kind                     r_pend_kind;
    logic [CNT_W-1:0]          r_pend_count;
    logic                      r_out_valid;
    t_kind                     r_out_kind;
    logic signed [H_W-1:0]     r_out_height;
    logic [CNT_W-1:0]          r_out_count;
    logic [ITER_W-1:0]         r_out_used;

    t_store_req                w_req;
    logic [H_W-1:0]            w_h_rdata;
    logic [L_W-1:0]            w_l_rdata;

    logic                      w_accept;
    logic                      w_load;
    logic                      w_read;
    logic                      w_out_free;
    logic [CNT_W-1:0]          w_base;
    logic                      w_store_ok;
    logic [CNT_W-1:0]          w_new_count;
    logic [ITER_W-1:0]         w_limit;
    logic                      w_short;
    logic [CNT_W-1:0]          w_nm1;
    logic [CNT_W-1:0]          w_nm2;
    logic [L_W-1:0]            w_len_eff;
    logic [L_W-1:0]            w_lim;
    logic signed [CAP_W-1:0]   w_cap;
    logic                      w_cur_low;
    logic signed [H_W-1:0]     w_cur_new;
    logic signed [H_W-1:0]     w_seam_a;
    logic signed [CAP_W-1:0]   w_seam_cap;
    logic                      w_h0_low;
    logic                      w_hlast_low;
    logic signed [H_W-1:0]     w_h0_new;
    logic signed [H_W-1:0]     w_hlast_new;
    logic [ITER_W-1:0]         w_pass_next;
    logic                      w_finish;

    glpl_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_h_rdata (w_h_rdata),
        .o_l_rdata (w_l_rdata)
    );

    assign o_stall     = (r_state != S_IDLE) || r_pend;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    assign w_load      = w_accept && (i_command == CMD_LOAD);
    assign w_read      = w_accept && (i_command == CMD_READ);
    assign w_out_free  = !r_out_valid || !i_stall;

    // a load after a finished set starts a new one
    assign w_base      = r_set_done ? '0 : r_count;
    assign w_store_ok  = w_base < CNT_W'(MAX_NODES);
    assign w_new_count = w_store_ok ? w_base + CNT_W'(1) : w_base;
    assign w_limit     = (r_max_iter > ITER_W'(PASS_CAP)) ? ITER_W'(PASS_CAP) : r_max_iter;
    assign w_short     = (w_new_count < CNT_W'(MIN_GRADE_NODES)) || (w_limit == '0);

    assign w_nm1 = r_count - CNT_W'(1);
    assign w_nm2 = r_count - CNT_W'(2);

    assign w_len_eff = (w_l_rdata < L_W'(ONE_METRE)) ? L_W'(ONE_METRE) : w_l_rdata;
    assign w_lim     = r_prod[PROD_W-1 -: L_W];

    // neighbour plus allowed rise; 26 bits holds any sum
    assign w_cap     = CAP_W'(r_prev) + $signed({2'b00, w_lim});
    assign w_cur_low = CAP_W'(r_hcur) > w_cap;
    assign w_cur_new = w_cur_low ? w_cap[H_W-1:0] : r_hcur;

    assign w_seam_a    = (r_h0 < r_hlast) ? r_h0 : r_hlast;
    assign w_seam_cap  = CAP_W'(w_seam_a) + $signed({2'b00, w_lim});
    assign w_h0_low    = CAP_W'(r_h0) > w_seam_cap;
    assign w_hlast_low = CAP_W'(r_hlast) > w_seam_cap;
    assign w_h0_new    = w_h0_low ? w_seam_cap[H_W-1:0] : r_h0;
    assign w_hlast_new = w_hlast_low ? w_seam_cap[H_W-1:0] : r_hlast;
    assign w_pass_next = r_pass + ITER_W'(1);
    assign w_finish    = !(r_moved || w_h0_low || w_hlast_low) || (w_pass_next == w_limit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load && i_last) begin
                    n_state = w_short ? S_DONE : S_START;
                end
            end
            S_START:    n_state = S_LOAD0;
            S_LOAD0:    n_state = S_FWD_RD;
            S_FWD_RD:   n_state = S_FWD_MUL;
            S_FWD_MUL:  n_state = S_FWD_CMP;
            S_FWD_CMP: begin
                n_state = (r_idx == w_nm1[IDX_W-1:0]) ? S_BWD_RD : S_FWD_RD;
            end
            S_BWD_RD:   n_state = S_BWD_MUL;
            S_BWD_MUL:  n_state = S_BWD_CMP;
            S_BWD_CMP: begin
                n_state = (r_idx == '0) ? S_SEAM_RD : S_BWD_RD;
            end
            S_SEAM_RD:  n_state = S_SEAM_MUL;
            S_SEAM_MUL: n_state = S_SEAM_CMP;
            S_SEAM_CMP: begin
                n_state = w_finish ? S_DONE : S_FWD_RD;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // store accesses; the unit is strictly sequential, so a write always lands
    // before the next read of the same entry
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_load && w_store_ok) begin
                    w_req.h_we    = 1'b1;
                    w_req.l_we    = 1'b1;
                    w_req.w_addr  = w_base[IDX_W-1:0];
                    w_req.h_wdata = i_natural_height;
                    w_req.l_wdata = i_segment_length;
                end
                if (w_read) begin
                    w_req.h_re    = 1'b1;
                    w_req.h_raddr = i_read_index;
                end
            end
            S_START: begin
                w_req.h_re    = 1'b1;
                w_req.h_raddr = '0;
            end
            S_FWD_RD: begin
                w_req.h_re    = 1'b1;
                w_req.h_raddr = r_idx;
                w_req.l_re    = 1'b1;
                w_req.l_raddr = r_idx - IDX_W'(1);
            end
            S_BWD_RD: begin
                w_req.h_re    = 1'b1;
                w_req.h_raddr = r_idx;
                w_req.l_re    = 1'b1;
                w_req.l_raddr = r_idx;
            end
            S_SEAM_RD: begin
                w_req.l_re    = 1'b1;
                w_req.l_raddr = w_nm2[IDX_W-1:0];
            end
            S_FWD_CMP, S_BWD_CMP: begin
                w_req.h_we    = w_cur_low;
                w_req.w_addr  = r_idx;
                w_req.h_wdata = w_cur_new;
            end
            S_SEAM_CMP: begin
                // only the higher end of the seam can drop
                priority if (w_h0_low) begin
                    w_req.h_we    = 1'b1;
                    w_req.w_addr  = '0;
                    w_req.h_wdata = w_h0_new;
                end else if (w_hlast_low) begin
                    w_req.h_we    = 1'b1;
                    w_req.w_addr  = w_nm1[IDX_W-1:0];
                    w_req.h_wdata = w_hlast_new;
                end
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_set_done  <= 1'b1;
            r_grade     <= GRADE_RESET;
            r_max_iter  <= ITER_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_moved     <= 1'b0;
            r_pass      <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_GRADE) begin
                    r_grade <= i_cfg_data[GRADE_W-1:0];
                end else if (i_cfg_index == CFG_MAX_ITER) begin
                    r_max_iter <= i_cfg_data[ITER_W-1:0];
                end
            end

            if (w_load) begin
                r_count    <= w_new_count;
                r_set_done <= i_last;
            end

            if (w_read) begin
                r_pend <= 1'b1;
            end else if (r_pend && w_out_free) begin
                r_pend <= 1'b0;
            end

            if ((r_pend || (r_state == S_DONE)) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD0: begin
                    r_pass  <= '0;
                    r_moved <= 1'b0;
                end
                S_FWD_CMP, S_BWD_CMP: begin
                    r_moved <= r_moved || w_cur_low;
                end
                S_SEAM_CMP: begin
                    r_pass  <= w_pass_next;
                    r_moved <= 1'b0;
                end
                default: begin
                    r_moved <= r_moved;
                end
            endcase
        end
    end

    // grading datapath and result payload
    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_pend_kind  <= ({1'b0, i_read_index} < r_count) ? KIND_DATA : KIND_RANGE;
            r_pend_count <= r_count;
        end

        priority if (r_pend && w_out_free) begin
            r_out_kind   <= r_pend_kind;
            r_out_height <= (r_pend_kind == KIND_DATA) ? w_h_rdata : '0;
            r_out_count  <= r_pend_count;
            r_out_used   <= '0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_kind   <= KIND_DONE;
            r_out_height <= '0;
            r_out_count  <= r_count;
            r_out_used   <= r_used;
        end

        unique case (r_state)
            S_IDLE: begin
                r_used <= '0;
            end
            S_LOAD0: begin
                r_prev <= w_h_rdata;
                r_h0   <= w_h_rdata;
                r_idx  <= IDX_W'(1);
            end
            S_FWD_MUL, S_BWD_MUL, S_SEAM_MUL: begin
                r_prod <= PROD_W'(r_grade) * PROD_W'(w_len_eff);
                r_hcur <= w_h_rdata;
            end
            S_FWD_CMP: begin
                r_prev <= w_cur_new;
                if (r_idx == w_nm1[IDX_W-1:0]) begin
                    r_hlast <= w_cur_new;
                    r_idx   <= w_nm2[IDX_W-1:0];
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            S_BWD_CMP: begin
                r_prev <= w_cur_new;
                if (r_idx == '0) begin
                    r_h0 <= w_cur_new;
                end else begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            S_SEAM_CMP: begin
                r_h0    <= w_h0_new;
                r_hlast <= w_hlast_new;
                r_prev  <= w_h0_new;
                r_idx   <= IDX_W'(1);
                r_used  <= w_pass_next;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_out_kind;
    assign o_graded_height   = r_out_height;
    assign o_node_count      = r_out_count;
    assign o_iterations_used = r_out_used;

endmodule

`default_nettype wire

### verif/grade_limited_profile_lowering_test.sv
`timescale 1ns / 1ps

module grade_limited_profile_lowering_test;

    import glpl_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int QUIET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 450;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_GAP      = 13;
    localparam int H_MAX        = 2 ** (H_W - 1) - 1;
    localparam int H_MIN        = -(2 ** (H_W - 1));
    localparam logic [L_W-1:0] L_MAX = '1;

    // indexes outside the register map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_command;
    logic signed [H_W-1:0] i_natural_height;
    logic [L_W-1:0]        i_segment_length;
    logic [IDX_W-1:0]      i_read_index;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_stall;
    logic [1:0]            o_kind;
    logic signed [H_W-1:0] o_graded_height;
    logic [CNT_W-1:0]      o_node_count;
    logic [ITER_W-1:0]     o_iterations_used;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    grade_limited_profile_lowering uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_natural_height  (i_natural_height),
        .i_segment_length  (i_segment_length),
        .i_read_index      (i_read_index),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_graded_height   (o_graded_height),
        .o_node_count      (o_node_count),
        .o_iterations_used (o_iterations_used),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    typedef struct {
        t_kind                 kind;
        logic signed [H_W-1:0] height;
        logic [CNT_W-1:0]      count;
        logic [ITER_W-1:0]     iters;
    } t_node_report;

    t_node_report awaited_reports[$];

    // shadow of the profile store and registers
    int                 profile_height [MAX_NODES];
    int unsigned        profile_length [MAX_NODES];
    int                 profile_count  = 0;
    bit                 profile_closed = 1'b1;
    logic [GRADE_W-1:0] grade_reg      = GRADE_RESET;
    logic [ITER_W-1:0]  pass_limit_reg = ITER_RESET;

    int error_count = 0;
    int sent_items  = 0;
    int cycle_count = 0;
    int sink_hold_len = 0;
    bit source_pace = 1'b1;
    bit sink_pace   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[grade_limited_profile_lowering] ERROR");
        $finish;
    end

    function automatic longint rise_over(int unsigned len);
        longint span;
        span = (len < ONE_METRE) ? ONE_METRE : len;
        return (longint'(grade_reg) * span) >>> 16;
    endfunction

    function automatic bit cap_height(int idx, longint ceiling);
        if (longint'(profile_height[idx]) > ceiling) begin
            profile_height[idx] = int'(ceiling);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // forward/backward relaxation with seam step; returns passes run
    function automatic int relax_profile(int n);
        int     limit;
        int     pass;
        int     i;
        bit     moved;
        longint lim;
        longint low_end;
        limit = (pass_limit_reg > PASS_CAP) ? PASS_CAP : int'(pass_limit_reg);
        if (n < MIN_GRADE_NODES)
            return 0;
        for (pass = 0; pass < limit; pass++) begin
            moved = 1'b0;
            for (i = 1; i < n; i++)
                moved |= cap_height(i, profile_height[i-1] + rise_over(profile_length[i-1]));
            for (i = n - 1; i > 0; i--)
                moved |= cap_height(i - 1, profile_height[i] + rise_over(profile_length[i-1]));
            lim = rise_over(profile_length[n-2]);
            low_end = (profile_height[0] < profile_height[n-1]) ? profile_height[0]
                                                                 : profile_height[n-1];
            moved |= cap_height(0, low_end + lim);
            moved |= cap_height(n - 1, low_end + lim);
            if (!moved)
                return pass + 1;
        end
        return limit;
    endfunction

    function automatic void apply_node_command(logic cmd, logic signed [H_W-1:0] height,
                                               logic [L_W-1:0] len, logic [IDX_W-1:0] ridx,
                                               logic last);
        t_node_report rep;
        rep.height = '0;
        rep.iters  = '0;
        if (cmd == CMD_LOAD) begin
            if (profile_closed) begin
                profile_count  = 0;
                profile_closed = 1'b0;
            end
            if (profile_count < MAX_NODES) begin
                profile_height[profile_count] = int'(height);
                profile_length[profile_count] = 32'(len);
                profile_count++;
            end
            if (!last)
                return;
            rep.iters      = ITER_W'(relax_profile(profile_count));
            profile_closed = 1'b1;
            rep.kind       = KIND_DONE;
        end else if (int'(ridx) < profile_count) begin
            rep.kind   = KIND_DATA;
            rep.height = profile_height[ridx][H_W-1:0];
        end else begin
            rep.kind = KIND_RANGE;
        end
        rep.count = CNT_W'(profile_count);
        awaited_reports.insert(awaited_reports.size(), rep);
    endfunction

    initial begin : result_check
        t_node_report want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (awaited_reports.size() == 0) begin
                    $error("unexpected result transfer, kind %0d", o_kind);
                    error_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        error_count++;
                    end
                    if (o_graded_height !== want.height) begin
                        $error("graded_height: expected %0d, got %0d",
                               want.height, o_graded_height);
                        error_count++;
                    end
                    if (o_node_count !== want.count) begin
                        $error("node_count: expected %0d, got %0d", want.count, o_node_count);
                        error_count++;
                    end
                    if (o_iterations_used !== want.iters) begin
                        $error("iterations_used: expected %0d, got %0d",
                               want.iters, o_iterations_used);
                        error_count++;
                    end
                end
            end
        end
    end

    // result side: random hold per transfer, plus an on-demand long hold
    initial begin : sink_drive
        int hold;
        forever begin
            if (sink_hold_len > 0) begin
                hold = sink_hold_len;
                sink_hold_len = 0;
            end else begin
                hold = sink_pace ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk);
            while (!(o_valid === 1'b1 && i_stall === 1'b0) && sink_hold_len == 0);
        end
    end

    // valid stays high on return; callers that consume time call release_input first
    task automatic send_item(logic cmd, logic signed [H_W-1:0] height, logic [L_W-1:0] len,
                             logic [IDX_W-1:0] ridx, logic last);
        int gap;
        gap = source_pace ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_natural_height <= height;
        i_segment_length <= len;
        i_read_index     <= ridx;
        i_last           <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        apply_node_command(cmd, height, len, ridx, last);
        sent_items++;
    endtask

    task automatic release_input();
        i_valid <= 1'b0;
    endtask

    task automatic settle();
        release_input();
        do @(posedge i_clk); while (awaited_reports.size() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_MAX_GRADE)
            grade_reg = data;
        else if (idx == CFG_MAX_ITER)
            pass_limit_reg = data[ITER_W-1:0];
    endtask

    task automatic release_config();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_settings(logic [GRADE_W-1:0] grade, logic [CFG_DATA_W-1:0] passes);
        settle();
        write_register(CFG_MAX_GRADE, grade);
        write_register(CFG_MAX_ITER, passes);
        release_config();
    endtask

    function automatic int next_height(int prev, int mode);
        int v;
        v = $urandom;
        if (mode == 0 || $urandom_range(0, 9) == 0)
            return (v <<< 8) >>> 8;
        if (mode == 1)
            v = prev + int'($urandom_range(0, 3000)) - 1500;
        else
            v = prev + int'($urandom_range(0, 200000)) - 100000;
        if (v > H_MAX)
            v = H_MAX;
        if (v < H_MIN)
            v = H_MIN;
        return v;
    endfunction

    function automatic logic [L_W-1:0] draw_length(int mode);
        case (mode)
            0:       return L_W'($urandom);
            1:       return L_W'($urandom_range(0, 2048));
            default: return L_W'($urandom_range(200, 320));
        endcase
    endfunction

    task automatic send_random_read();
        int pick;
        if ($urandom_range(0, 3) == 0)
            pick = $urandom_range(0, MAX_NODES - 1);
        else
            pick = $urandom_range(0, profile_count + 1);
        if (pick > MAX_NODES - 1)
            pick = MAX_NODES - 1;
        send_item(CMD_READ, $urandom, $urandom, pick, $urandom_range(0, 1));
    endtask

    task automatic send_random_set(int nodes);
        int h_mode;
        int l_mode;
        int k;
        int walk;
        h_mode = $urandom_range(0, 2);
        l_mode = $urandom_range(0, 2);
        walk = int'($urandom_range(0, 4000000)) - 2000000;
        for (k = 0; k < nodes; k++) begin
            if ($urandom_range(0, 15) == 0)
                send_random_read();
            walk = next_height(walk, h_mode);
            send_item(CMD_LOAD, walk, draw_length(l_mode), $urandom, k == nodes - 1);
        end
    endtask

    task automatic test_empty_store_reads();
        send_item(CMD_READ, H_MIN, L_MAX, 0, 1'b0);
        send_item(CMD_READ, H_MAX, 0, MAX_NODES - 1, 1'b1);
    endtask

    task automatic test_short_sets();
        send_item(CMD_LOAD, H_MAX, L_MAX, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 1, 1'b0);
        send_item(CMD_LOAD, H_MIN, 0, 0, 1'b0);
        send_item(CMD_LOAD, H_MAX, 0, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 1, 1'b0);
    endtask

    task automatic test_extreme_profile();
        send_item(CMD_LOAD, H_MAX, 0, 0, 1'b0);
        send_item(CMD_LOAD, H_MIN, 255, 0, 1'b0);
        send_item(CMD_READ, 0, 0, 1, 1'b0);       // ungraded while loading
        send_item(CMD_LOAD, 0, 256, 0, 1'b0);
        send_item(CMD_READ, 0, 0, 5, 1'b0);
        send_item(CMD_LOAD, H_MAX, L_MAX, 0, 1'b0);
        send_item(CMD_LOAD, -1, 0, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 0, 1'b0);
        send_item(CMD_READ, 0, 0, 3, 1'b0);
        send_item(CMD_READ, 0, 0, 5, 1'b0);
    endtask

    task automatic test_pass_limit_zero();
        program_settings(GRADE_RESET, 0);
        send_item(CMD_LOAD, 0, 256, 0, 1'b0);
        send_item(CMD_LOAD, H_MAX, 256, 0, 1'b0);
        send_item(CMD_LOAD, 0, 256, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 1, 1'b0);
    endtask

    task automatic test_unused_registers();
        settle();
        write_register(CFG_MAX_ITER, ITER_RESET);
        write_register(CFG_UNUSED_LO, '1);
        write_register(CFG_UNUSED_HI, 16'h5A5A);
        release_config();
        send_item(CMD_LOAD, 0, 512, 0, 1'b0);
        send_item(CMD_LOAD, 100000, 512, 0, 1'b0);
        send_item(CMD_LOAD, 50000, 512, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int phase;
        int sets;
        int nodes;
        int pick;
        int stop_at;
        logic [GRADE_W-1:0]    grade;
        logic [CFG_DATA_W-1:0] passes;
        stop_at = sent_items + RANDOM_ITEMS;
        phase = 0;
        while (sent_items < stop_at) begin
            grade  = $urandom;
            passes = $urandom_range(1, PASS_CAP);
            case (phase % 8)
                0: begin
                    grade  = GRADE_RESET;
                    passes = ITER_RESET;
                end
                1: grade = '0;
                2: grade = '1;
                3: passes = 1;
                4: passes = 0;
                5: passes = '1;       // saturates to the pass cap
                6: begin
                    grade  = $urandom_range(0, 2000);
                    passes = $urandom_range(0, 127);
                end
                default: ;
            endcase
            program_settings(grade, passes);
            source_pace = (phase % 3) != 2;
            sink_pace   = (phase % 4) != 3;
            for (sets = 0; sets < 6; sets++) begin
                pick = $urandom_range(0, 31);
                if (pick == 0)
                    nodes = $urandom_range(1, 2);
                else if (pick == 1)
                    nodes = $urandom_range(24, 48);
                else
                    nodes = $urandom_range(3, 12);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) send_random_read();
                send_random_set(nodes);
                repeat ($urandom_range(0, 4)) send_random_read();
            end
            phase++;
        end
        source_pace = 1'b1;
        sink_pace   = 1'b1;
    endtask

    // fill every entry, then offer loads that must be dropped; the last one still grades
    task automatic test_store_full();
        int k;
        int walk;
        program_settings($urandom, 2);
        walk = 0;
        for (k = 0; k < MAX_NODES + 3; k++) begin
            walk = next_height(walk, 1);
            send_item(CMD_LOAD, walk, draw_length(1), $urandom, k == MAX_NODES + 2);
        end
        send_item(CMD_READ, 0, 0, MAX_NODES - 1, 1'b0);
        send_item(CMD_READ, 0, 0, 0, 1'b0);
        send_random_read();
    endtask

    task automatic test_backpressure();
        settle();
        source_pace = 1'b0;
        sink_hold_len = LONG_HOLD;
        send_random_set(5);
        repeat (20) send_random_read();
        settle();
        source_pace = 1'b1;
    endtask

    initial begin : run_tests
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_command        <= CMD_LOAD;
        i_natural_height <= '0;
        i_segment_length <= '0;
        i_read_index     <= '0;
        i_last           <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_MAX_GRADE;
        i_cfg_data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store_reads();
        test_short_sets();
        test_extreme_profile();
        test_pass_limit_zero();
        test_unused_registers();
        test_random_traffic();
        test_store_full();
        test_backpressure();
        settle();

        if (error_count == 0)
            $display("[grade_limited_profile_lowering] OK");
        else
            $display("[grade_limited_profile_lowering] ERROR");
        $finish;
    end

endmodule
